### rtl/core/frame_fed_lamp_qualifier_assert.svh
`ifndef FRAME_FED_LAMP_QUALIFIER_ASSERT_SVH
`define FRAME_FED_LAMP_QUALIFIER_ASSERT_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define FFL_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("same-cycle check failed");

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define FFL_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/core/ffl_pkg.sv
package ffl_pkg;

	// input item kinds
	localparam logic ACT_BYTE = 1'b0;
	localparam logic ACT_TICK = 1'b1;

	// configuration register indexes
	localparam logic REG_BOARD_ID   = 1'b0;
	localparam logic REG_INIT_COUNT = 1'b1;

	localparam int BOARD_ID_W = 5;
	localparam int REG_COUNT_W = 6;
	localparam int CFG_DATA_W = 6;
	localparam int POS_W = 8;
	localparam int TIMEOUT_W = 3;
	localparam int NUM_SLOTS = 4;
	localparam int LAMP_W = 32;

	localparam logic [REG_COUNT_W-1:0] REG_COUNT_RESET = 6'd6;
	localparam logic [BOARD_ID_W-1:0]  BOARD_ID_RESET  = 5'd1;

	localparam logic [7:0] START_BYTE     = 8'h01;
	localparam logic [7:0] FUNC_READ      = 8'h03;
	localparam logic [7:0] FUNC_EXCEPTION = 8'h83;
	localparam logic [TIMEOUT_W-1:0] TIMEOUT_LIMIT = 3'd4;

	typedef logic [2:0] mode_t;
	localparam mode_t MODE_OFF         = 3'd0;
	localparam mode_t MODE_ON          = 3'd1;
	localparam mode_t MODE_FIRST_MIXED = 3'd2;
	localparam mode_t MODE_BLINK       = 3'd6;

	// captured slot feeding each group of eight channels
	localparam logic [1:0] GROUP_SLOT [4] = '{2'd2, 2'd0, 2'd3, 2'd1};

	// frame parser -> channel bank
	typedef struct packed {
		logic                      done;
		logic                      receiving;
		logic [NUM_SLOTS-1:0][7:0] slot_bytes;
	} frame_evt_t;

endpackage

### rtl/core/ffl_frame_rx.sv
module ffl_frame_rx
	import ffl_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                  step_en,
	input  logic                  action,
	input  logic [7:0]            rx_byte,
	output frame_evt_t            evt
);

	logic [BOARD_ID_W-1:0]     board_id_q;
	logic [REG_COUNT_W-1:0]    reg_count_q, reg_count_nxt;
	logic [POS_W-1:0]          pos_q, pos_nxt;
	logic                      in_frame_q, in_frame_nxt;
	logic [TIMEOUT_W-1:0]      timeout_q, timeout_nxt;
	logic [NUM_SLOTS-1:0][7:0] cap_q, cap_nxt;

	logic [POS_W-1:0]  pos_inc;
	logic [POS_W-1:0]  slot_base;
	logic [POS_W-1:0]  count_x2;
	logic [POS_W-1:0]  end_pos;
	logic [TIMEOUT_W-1:0] timeout_inc;
	logic              bad;
	logic              done;

	assign pos_inc     = pos_q + POS_W'(1);
	assign slot_base   = {1'b0, board_id_q, 2'b00};
	assign count_x2    = {1'b0, reg_count_q, 1'b0};
	assign end_pos     = count_x2 + POS_W'(3);
	assign timeout_inc = timeout_q + TIMEOUT_W'(1);

	always_comb begin
		reg_count_nxt = reg_count_q;
		pos_nxt       = pos_q;
		in_frame_nxt  = in_frame_q;
		timeout_nxt   = timeout_q;
		cap_nxt       = cap_q;
		bad           = 1'b0;
		done          = 1'b0;
		if (action == ACT_BYTE) begin
			if (in_frame_q) begin
				for (int s = 0; s < NUM_SLOTS; s++) begin
					if (pos_inc == slot_base + POS_W'(s))
						cap_nxt[s] = rx_byte;
				end
				if (pos_q == POS_W'(1) && rx_byte != FUNC_READ) begin
					bad = 1'b1;
					if (rx_byte == FUNC_EXCEPTION && reg_count_q > REG_COUNT_W'(1))
						reg_count_nxt = reg_count_q - REG_COUNT_W'(1);
				end else if (pos_q == POS_W'(2) && rx_byte != count_x2) begin
					bad = 1'b1;
				end
				if (bad) begin
					in_frame_nxt = 1'b0;
					pos_nxt      = '0;
				end else if (pos_inc == end_pos) begin
					in_frame_nxt = 1'b0;
					pos_nxt      = '0;
					done         = 1'b1;
				end else begin
					pos_nxt = pos_inc;
				end
			end
			// a start byte received while idle, or one that closes or aborts a frame, opens the next one
			if (rx_byte == START_BYTE && !in_frame_nxt) begin
				in_frame_nxt = 1'b1;
				pos_nxt      = POS_W'(1);
			end
		end else if (in_frame_q) begin
			if (timeout_inc > TIMEOUT_LIMIT) begin
				timeout_nxt  = '0;
				in_frame_nxt = 1'b0;
				pos_nxt      = '0;
			end else begin
				timeout_nxt = timeout_inc;
			end
		end
	end

	// slot bytes go out before the start-of-frame clear
	assign evt.done       = done;
	assign evt.receiving  = in_frame_nxt;
	assign evt.slot_bytes = cap_nxt;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			board_id_q  <= BOARD_ID_RESET;
			reg_count_q <= REG_COUNT_RESET;
			pos_q       <= '0;
			in_frame_q  <= 1'b0;
			timeout_q   <= '0;
			cap_q       <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_BOARD_ID: begin
					board_id_q <= cfg_wr_data[BOARD_ID_W-1:0];
				end
				REG_INIT_COUNT: begin
					reg_count_q <= (cfg_wr_data == '0) ? REG_COUNT_W'(1)
						: cfg_wr_data[REG_COUNT_W-1:0];
				end
				default: begin
					board_id_q <= board_id_q;
				end
			endcase
		end else if (step_en) begin
			reg_count_q <= reg_count_nxt;
			pos_q       <= pos_nxt;
			in_frame_q  <= in_frame_nxt;
			timeout_q   <= timeout_nxt;
			if (action == ACT_BYTE && rx_byte == START_BYTE && in_frame_nxt
				&& pos_nxt == POS_W'(1))
				cap_q <= '0;
			else
				cap_q <= cap_nxt;
		end
	end

`include "frame_fed_lamp_qualifier_assert.svh"

	`FFL_ASSERT_NOW(a_idle_pos_zero, !in_frame_q, pos_q == '0)
	`FFL_ASSERT_NOW(a_timeout_range, 1'b1, timeout_q <= TIMEOUT_LIMIT)
	`FFL_ASSERT_NOW(a_reg_count_nonzero, 1'b1, reg_count_q != '0)

endmodule

### rtl/core/ffl_channel_bank.sv
module ffl_channel_bank
	import ffl_pkg::*;
#(
	parameter int NUM_GROUPS  = 4,
	parameter int HISTORY_LEN = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step_en,
	input  logic              action,
	input  frame_evt_t        evt,
	output logic [LAMP_W-1:0] lamp_next
);

	localparam int NCH = 8 * NUM_GROUPS;

	logic [HISTORY_LEN-1:0] hist_q [NCH];
	mode_t                  mode_q [NCH];
	logic [NCH-1:0]         lvl_q, lvl_nxt;
	logic                   phase_q;
	logic                   upd;
	logic                   drive;
	logic                   tick;

	assign upd   = step_en && action == ACT_BYTE && evt.done;
	assign tick  = step_en && action == ACT_TICK;
	assign drive = tick && phase_q;

	for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
		localparam int G = ch / 8;
		localparam int K = ch % 8;

		logic                   sample;
		logic [HISTORY_LEN-1:0] hist_nxt;
		mode_t                  mode_nxt;

		assign sample   = evt.slot_bytes[GROUP_SLOT[G]][K];
		assign hist_nxt = {hist_q[ch][HISTORY_LEN-2:0], sample};

		always_comb begin
			if (&hist_nxt)
				mode_nxt = MODE_ON;
			else if (hist_nxt == '0)
				mode_nxt = MODE_OFF;
			else if (mode_q[ch] < MODE_FIRST_MIXED)
				mode_nxt = MODE_FIRST_MIXED;
			else if (mode_q[ch] < MODE_BLINK)
				mode_nxt = mode_q[ch] + mode_t'(1);
			else
				mode_nxt = MODE_BLINK;
		end

		always_comb begin
			lvl_nxt[ch] = lvl_q[ch];
			if (drive) begin
				case (mode_q[ch])
					MODE_ON:    lvl_nxt[ch] = 1'b1;
					MODE_OFF:   lvl_nxt[ch] = 1'b0;
					MODE_BLINK: lvl_nxt[ch] = !lvl_q[ch];
					default:    lvl_nxt[ch] = lvl_q[ch];
				endcase
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				hist_q[ch] <= '0;
				mode_q[ch] <= MODE_OFF;
			end else if (upd) begin
				hist_q[ch] <= hist_nxt;
				mode_q[ch] <= mode_nxt;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q   <= '0;
			phase_q <= 1'b0;
		end else begin
			lvl_q <= lvl_nxt;
			if (tick)
				phase_q <= !phase_q;
		end
	end

	assign lamp_next = LAMP_W'(lvl_nxt);

endmodule

### rtl/core/frame_fed_lamp_qualifier.sv
// Lamp qualifier fed by register-read response frames.
// Item channel (item_valid / item_stall): one beat is either a received serial
// byte (action = 0, rx_byte) or a timer tick (action = 1, rx_byte ignored).
// Result channel (result_valid / result_stall): exactly one beat per item,
// carrying lamp_levels, frame_done (this byte closed a good frame) and
// receiving (a frame is open after this item).
// Config port: cfg_wr_en with cfg_index 0 = board_id, 1 = initial_reg_count;
// writing the count also reloads the live register count (0 counts as 1).
// An item is taken into the input register and its result into the result
// register. Throughput: one item per cycle while the result is not stalled; all
// frame parsing and the 32 channel updates sit between those two registers.
// Result stall: the result register holds; the input register takes at most
// one more beat, and item_stall is high while it holds one and the result is
// stalled, so nothing is dropped or repeated.
// Reset (arst_n low): all history, modes and levels clear, no frame is open,
// board_id = 1, register count = 6. No clearing pass is needed.
module frame_fed_lamp_qualifier
	import ffl_pkg::*;
#(
	parameter int NUM_GROUPS  = 4,
	parameter int HISTORY_LEN = 5
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_wr_en,
	input  logic                  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wr_data,
	input  logic                  item_valid,
	output logic                  item_stall,
	input  logic                  action,
	input  logic [7:0]            rx_byte,
	output logic                  result_valid,
	input  logic                  result_stall,
	output logic [LAMP_W-1:0]     lamp_levels,
	output logic                  frame_done,
	output logic                  receiving
);

	// input stage
	logic       item_valid_s1;
	logic       action_s1;
	logic [7:0] rx_byte_s1;

	// result stage
	logic              result_valid_s2;
	logic [LAMP_W-1:0] lamp_levels_s2;
	logic              frame_done_s2;
	logic              receiving_s2;

	logic              advance;
	logic              step_en;
	frame_evt_t        evt;
	logic [LAMP_W-1:0] lamp_next;

	// the result slot is free when empty or being taken this cycle
	assign advance    = !result_valid_s2 || !result_stall;
	assign step_en    = item_valid_s1 && advance;
	assign item_stall = item_valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			item_valid_s1 <= 1'b0;
		else if (!item_stall)
			item_valid_s1 <= item_valid;
	end

	always_ff @(posedge clk) begin
		if (item_valid && !item_stall) begin
			action_s1  <= action;
			rx_byte_s1 <= rx_byte;
		end
	end

	ffl_frame_rx u_frame_rx (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_index   (cfg_index),
		.cfg_wr_data (cfg_wr_data),
		.step_en     (step_en),
		.action      (action_s1),
		.rx_byte     (rx_byte_s1),
		.evt         (evt)
	);

	ffl_channel_bank #(
		.NUM_GROUPS  (NUM_GROUPS),
		.HISTORY_LEN (HISTORY_LEN)
	) u_channel_bank (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (step_en),
		.action    (action_s1),
		.evt       (evt),
		.lamp_next (lamp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			result_valid_s2 <= 1'b0;
		else if (advance)
			result_valid_s2 <= item_valid_s1;
	end

	always_ff @(posedge clk) begin
		if (step_en) begin
			lamp_levels_s2 <= lamp_next;
			frame_done_s2  <= (action_s1 == ACT_BYTE) && evt.done;
			receiving_s2   <= evt.receiving;
		end
	end

	assign result_valid = result_valid_s2;
	assign lamp_levels  = lamp_levels_s2;
	assign frame_done   = frame_done_s2;
	assign receiving    = receiving_s2;

`include "frame_fed_lamp_qualifier_assert.svh"

	`FFL_ASSERT_NOW(a_stall_needs_item, item_stall, item_valid_s1)
	`FFL_ASSERT_NEXT(a_step_gives_result, step_en, result_valid_s2)
	`FFL_ASSERT_NEXT(a_held_item_kept, item_stall, item_valid_s1 && $stable({action_s1, rx_byte_s1}))

endmodule
